FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define HBT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define HBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/hbt_pkg.sv
// Types and constants for the heartbeat timeout table.
package hbt_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 63;
	localparam int TO_W   = 32;

	localparam logic [TO_W-1:0] TIMEOUT_RESET = 32'd60000000;

	localparam logic CMD_HEARTBEAT = 1'b0;
	localparam logic CMD_TICK      = 1'b1;

	typedef enum logic [2:0] {
		KIND_UPDATED  = 3'd0,
		KIND_INSERTED = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_EXPIRED  = 3'd3,
		KIND_NONE     = 3'd4
	} kind_t;

	// Item travelling down the cell row, with what it has gathered so far.
	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] now;
		logic              hit;       // heartbeat id found and refreshed
		logic              free_vld;  // a free slot has been seen
		logic              pend_vld;  // an expired entry waits to be reported
		logic [ID_W-1:0]   pend_id;
	} token_t;

	// One result item.
	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic            last;
	} res_t;

	// Insert request broadcast from the row tail to all cells.
	typedef struct packed {
		logic              we;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] now;
	} slot_wr_t;

endpackage

FILE: design/heartbeat_timeout_table_top.sv
// Top level of the heartbeat timeout table: input stage, cell row, row tail, output register.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | command, detector_id, time_now
//  out     | out_valid/out_stall| kind, dead_or_sender_id, last
//  cfg     | cfg_we             | cfg_wdata (timeout_us)
//
// An item walks the row one cell per cycle while the row advances, through the input
// stage, each cell register and the output register; one item at a time.
// The row advances only while the output register is empty or being taken,
// so out_stall holds the item in place. A tick gives up to TABLE_DEPTH results.
// Reset clears all slot valid marks at once; timeout_us resets to 60000000.
module heartbeat_timeout_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [hbt_pkg::ID_W-1:0]   detector_id,
	input  logic [hbt_pkg::TIME_W-1:0] time_now,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 kind,
	output logic [hbt_pkg::ID_W-1:0]   dead_or_sender_id,
	output logic                       last,
	input  logic                       cfg_we,
	input  logic [hbt_pkg::TO_W-1:0]   cfg_wdata
);
	import hbt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [TO_W-1:0]  timeout_q;
	logic             busy_q;
	logic             in_vld_q;
	token_t           in_tok_q;
	logic             out_vld_q;
	res_t             out_res_q;

	logic             accept;
	logic             adv;
	logic             chain_vld [0:TABLE_DEPTH];
	token_t           chain_tok [0:TABLE_DEPTH];
	logic [IDX_W-1:0] chain_free [0:TABLE_DEPTH];
	logic             cell_emit [0:TABLE_DEPTH-1];
	res_t             cell_res [0:TABLE_DEPTH-1];
	logic             tail_vld;
	token_t           tail_tok;
	res_t             tail_res;
	slot_wr_t         wr;
	logic             sel_vld;
	res_t             sel_res;

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign adv      = !out_vld_q || !out_stall;

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Busy from transfer until the row tail gives the final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (adv && tail_vld) begin
			busy_q <= 1'b0;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q <= 1'b0;
		end else if (accept) begin
			in_vld_q <= 1'b1;
		end else if (adv) begin
			in_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_tok_q.cmd      <= command;
			in_tok_q.id       <= detector_id;
			in_tok_q.now      <= time_now;
			in_tok_q.hit      <= 1'b0;
			in_tok_q.free_vld <= 1'b0;
			in_tok_q.pend_vld <= 1'b0;
			in_tok_q.pend_id  <= '0;
		end
	end

	assign chain_vld[0]  = in_vld_q;
	assign chain_tok[0]  = in_tok_q;
	assign chain_free[0] = '0;

	// Row of slot cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		hbt_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.timeout    (timeout_q),
			.tok_vld_i  (chain_vld[i]),
			.tok_i      (chain_tok[i]),
			.free_idx_i (chain_free[i]),
			.wr         (wr),
			.wr_idx     (chain_free[TABLE_DEPTH]),
			.tok_vld_o  (chain_vld[i+1]),
			.tok_o      (chain_tok[i+1]),
			.free_idx_o (chain_free[i+1]),
			.emit       (cell_emit[i]),
			.res        (cell_res[i])
		);
	end

	assign tail_vld = chain_vld[TABLE_DEPTH];
	assign tail_tok = chain_tok[TABLE_DEPTH];

	// Row tail: final result of the item and the insert decision
	always_comb begin
		tail_res.last = 1'b1;
		if (tail_tok.cmd == CMD_HEARTBEAT) begin
			tail_res.id = tail_tok.id;
			if (tail_tok.hit) begin
				tail_res.kind = KIND_UPDATED;
			end else if (tail_tok.free_vld) begin
				tail_res.kind = KIND_INSERTED;
			end else begin
				tail_res.kind = KIND_FULL;
			end
		end else if (tail_tok.pend_vld) begin
			tail_res.kind = KIND_EXPIRED;
			tail_res.id   = tail_tok.pend_id;
		end else begin
			tail_res.kind = KIND_NONE;
			tail_res.id   = '0;
		end
		wr.we  = tail_vld && (tail_tok.cmd == CMD_HEARTBEAT) &&
		         !tail_tok.hit && tail_tok.free_vld;
		wr.id  = tail_tok.id;
		wr.now = tail_tok.now;
	end

	// Pick the one source that has a result this cycle
	always_comb begin
		sel_vld = tail_vld;
		sel_res = tail_res;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (cell_emit[i]) begin
				sel_vld = 1'b1;
				sel_res = cell_res[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= sel_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && sel_vld) begin
			out_res_q <= sel_res;
		end
	end

	assign out_valid         = out_vld_q;
	assign kind              = out_res_q.kind;
	assign dead_or_sender_id = out_res_q.id;
	assign last              = out_res_q.last;

endmodule

FILE: design/hbt_cell.sv
// One table slot of the row: holds an entry and processes the passing item.
module hbt_cell #(
	parameter int IDX_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic [hbt_pkg::TO_W-1:0] timeout,
	input  logic                    tok_vld_i,
	input  hbt_pkg::token_t         tok_i,
	input  logic [IDX_W-1:0]        free_idx_i,
	input  hbt_pkg::slot_wr_t       wr,
	input  logic [IDX_W-1:0]        wr_idx,
	output logic                    tok_vld_o,
	output hbt_pkg::token_t         tok_o,
	output logic [IDX_W-1:0]        free_idx_o,
	output logic                    emit,
	output hbt_pkg::res_t           res
);
	import hbt_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] seen_q;
	logic              tok_vld_q;
	token_t            tok_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic              is_hb;
	logic              match;
	logic              aged;
	logic              expired;
	logic [TIME_W-1:0] age;
	logic              wr_me;
	token_t            tok_nx;
	logic [IDX_W-1:0]  free_idx_nx;

	// Slot checks against the item in front of this cell
	always_comb begin
		is_hb   = tok_vld_i && (tok_i.cmd == CMD_HEARTBEAT);
		match   = valid_q && (id_q == tok_i.id);
		age     = tok_i.now - seen_q;
		aged    = (tok_i.now >= seen_q) &&
		          (age >= {{(TIME_W-TO_W){1'b0}}, timeout});
		expired = tok_vld_i && (tok_i.cmd == CMD_TICK) && valid_q && aged;
		wr_me   = wr.we && (wr_idx == MY_IDX);
	end

	// Update what the item carries on to the next cell
	always_comb begin
		tok_nx      = tok_i;
		free_idx_nx = free_idx_i;
		if (is_hb && match) begin
			tok_nx.hit = 1'b1;
		end
		if (is_hb && !valid_q && !tok_i.free_vld) begin
			tok_nx.free_vld = 1'b1;
			free_idx_nx     = MY_IDX;
		end
		if (expired) begin
			tok_nx.pend_vld = 1'b1;
			tok_nx.pend_id  = id_q;
		end
	end

	// A new expiry pushes out the one held before it, not the final one
	always_comb begin
		emit      = expired && tok_i.pend_vld;
		res.kind  = KIND_EXPIRED;
		res.id    = tok_i.pend_id;
		res.last  = 1'b0;
	end

	// Slot valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			if (wr_me) begin
				valid_q <= 1'b1;
			end else if (expired) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_me) begin
				id_q   <= wr.id;
				seen_q <= wr.now;
			end else if (is_hb && match) begin
				seen_q <= tok_i.now;
			end
		end
	end

	// Hand the item to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else if (adv) begin
			tok_vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q      <= tok_nx;
			free_idx_q <= free_idx_nx;
		end
	end

	assign tok_vld_o  = tok_vld_q;
	assign tok_o      = tok_q;
	assign free_idx_o = free_idx_q;

endmodule

FILE: design/hbt_checker.sv
// Port-level checks on the heartbeat timeout table, bound to the top level.
`include "assert_macros.svh"

module hbt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [2:0]                 kind,
	input logic [hbt_pkg::ID_W-1:0]   dead_or_sender_id,
	input logic                       last
);
	import hbt_pkg::*;

	// One item at a time: a transfer closes the input
	`HBT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input open after transfer")

	// A waiting result stays
	`HBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

	// Only expiries can be followed by more results of the same item
	`HBT_ASSERT_IMPL(a_single_last, out_valid && kind != KIND_EXPIRED, last, "single result not last")

	// A tick with no expiry reports id zero
	`HBT_ASSERT_IMPL(a_none_id, out_valid && kind == KIND_NONE, dead_or_sender_id == '0, "none_expired id")

	// Result kind codes stay in range
	`HBT_ASSERT_IMPL(a_kind_range, out_valid, kind <= KIND_NONE, "bad result kind")

endmodule

bind heartbeat_timeout_table_top hbt_checker u_hbt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.kind              (kind),
	.dead_or_sender_id (dead_or_sender_id),
	.last              (last)
);

FILE: test/tb_heartbeat_timeout_table_top.sv
// Self-checking testbench for the heartbeat timeout table: queued events, predicted reports.
module tb_heartbeat_timeout_table_top;
	import hbt_pkg::*;

	localparam int DEPTH      = 16;
	localparam int LATENCY    = DEPTH + 2;
	localparam int POOL       = 20;
	localparam int LIMIT_TIME = 5000000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// one queued detector event
	typedef struct {
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] now;
		bit                drain;  // hold back until all reports are in
	} det_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              command = 1'b0;
	logic [ID_W-1:0]   detector_id = '0;
	logic [TIME_W-1:0] time_now = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        kind;
	logic [ID_W-1:0]   dead_or_sender_id;
	logic              last;
	logic              cfg_we = 1'b0;
	logic [TO_W-1:0]   cfg_wdata = '0;

	// predicted table contents and register
	logic              live_slot [DEPTH];
	logic [ID_W-1:0]   live_id   [DEPTH];
	logic [TIME_W-1:0] live_seen [DEPTH];
	logic [TO_W-1:0]   timeout_cfg = TIMEOUT_RESET;

	det_event_t        pending_events [$];
	res_t              expected_reports [$];
	det_event_t        next_event;
	logic [ID_W-1:0]   id_pool [POOL];
	logic [TIME_W-1:0] clock_us = '0;
	bit                quiet = 1'b0;
	int                mismatch_count = 0;

	heartbeat_timeout_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.detector_id      (detector_id),
		.time_now         (time_now),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.dead_or_sender_id(dead_or_sender_id),
		.last             (last),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		foreach (live_slot[i]) live_slot[i] = 1'b0;
		foreach (live_id[i]) live_id[i] = '0;
		foreach (live_seen[i]) live_seen[i] = '0;
	end

	function automatic bit random_idle();
		return !quiet && ($urandom_range(0, 99) < 7);
	endfunction

	// Work out the reports one event causes and update the predicted table.
	function automatic void predict_table_reports(input logic cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] now);
		res_t rep;
		res_t held;
		bit   have_held;
		int   free_slot;
		have_held = 1'b0;
		free_slot = -1;
		rep.id = id;
		rep.last = 1'b1;
		if (cmd == CMD_HEARTBEAT) begin
			// refresh a known id, else take the lowest free slot
			for (int i = 0; i < DEPTH; i++) begin
				if (live_slot[i] && live_id[i] == id) begin
					live_seen[i] = now;
					rep.kind = KIND_UPDATED;
					expected_reports.push_back(rep);
					return;
				end
			end
			for (int i = DEPTH - 1; i >= 0; i--)
				if (!live_slot[i]) free_slot = i;
			if (free_slot < 0) begin
				rep.kind = KIND_FULL;
			end else begin
				live_slot[free_slot] = 1'b1;
				live_id[free_slot] = id;
				live_seen[free_slot] = now;
				rep.kind = KIND_INSERTED;
			end
			expected_reports.push_back(rep);
			return;
		end
		// tick: expire every aged entry in slot order; last flag goes on the final one
		for (int i = 0; i < DEPTH; i++) begin
			if (live_slot[i] && now >= live_seen[i] &&
			    {1'b0, now} - {1'b0, live_seen[i]} >= {32'b0, timeout_cfg}) begin
				if (have_held) expected_reports.push_back(held);
				held.kind = KIND_EXPIRED;
				held.id = live_id[i];
				held.last = 1'b0;
				have_held = 1'b1;
				live_slot[i] = 1'b0;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			expected_reports.push_back(held);
		end else begin
			rep.kind = KIND_NONE;
			rep.id = '0;
			expected_reports.push_back(rep);
		end
	endfunction

	// Input driver: offers queued events, holds the payload while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_table_reports(command, detector_id, time_now);
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && !random_idle() &&
				    !(pending_events[0].drain && expected_reports.size() != 0)) begin
					next_event = pending_events.pop_front();
					in_valid <= 1'b1;
					command <= next_event.cmd;
					detector_id <= next_event.id;
					time_now <= next_event.now;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_report();
		res_t want;
		if (expected_reports.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected report kind %0d id %h last %0d",
				$time, kind, dead_or_sender_id, last);
		end else begin
			want = expected_reports.pop_front();
			if (kind !== want.kind || dead_or_sender_id !== want.id || last !== want.last) begin
				mismatch_count++;
				$display("%0t: expected kind %0d id %h last %0d, got kind %0d id %h last %0d",
					$time, want.kind, want.id, want.last, kind, dead_or_sender_id, last);
			end
		end
	endtask

	// Output monitor: random stall, checks each transfer in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_report();
			out_stall <= random_idle();
		end
	end

	function automatic void queue_event(input logic cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] now, input bit drain);
		det_event_t ev;
		ev.cmd = cmd;
		ev.id = id;
		ev.now = now;
		ev.drain = drain;
		pending_events.push_back(ev);
	endfunction

	// Next event time: mostly forward in steps scaled to the timeout,
	// sometimes backwards, sometimes anywhere.
	function automatic logic [TIME_W-1:0] advance_clock(input logic [TIME_W-1:0] t);
		logic [63:0]  step;
		logic [63:0]  rnd;
		int unsigned  pick;
		pick = $urandom_range(0, 99);
		rnd = {$urandom, $urandom};
		step = ({32'b0, timeout_cfg} * $urandom_range(0, 6)) / 4 + $urandom_range(0, 2);
		if (pick < 5)
			return rnd[TIME_W-1:0];
		if (pick < 12)
			return (t > step[TIME_W-1:0]) ? t - step[TIME_W-1:0] : t;
		if (pick < 35)
			return t + $urandom_range(0, 1);
		return t + step[TIME_W-1:0];
	endfunction

	task automatic queue_random_phase(input int count);
		logic [ID_W-1:0] id;
		logic [63:0]     rnd;
		bit              tick;
		repeat (count) begin
			clock_us = advance_clock(clock_us);
			tick = ($urandom_range(0, 99) < 35);
			rnd = {$urandom, $urandom};
			id = ($urandom_range(0, 99) < 15) ? rnd[ID_W-1:0] : id_pool[$urandom_range(0, POOL - 1)];
			queue_event(tick ? CMD_TICK : CMD_HEARTBEAT, id, clock_us, $urandom_range(0, 99) < 5);
		end
	endtask

	// Sampled at the falling edge, after all edge activity has settled.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0);
	endtask

	task automatic write_timeout(input logic [TO_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		timeout_cfg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus sequence
	initial begin
		logic [TO_W-1:0] phase_timeout [5];
		foreach (id_pool[i]) id_pool[i] = $urandom_range(0, 16'hFFFF);
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, insert extremes, update, exact-timeout boundary
		queue_event(CMD_TICK, 16'h5A5A, '0, 1'b0);
		queue_event(CMD_HEARTBEAT, 16'h0000, '0, 1'b0);
		queue_event(CMD_HEARTBEAT, 16'hFFFF, TIME_MAX, 1'b0);
		queue_event(CMD_HEARTBEAT, 16'h0000, 63'd100, 1'b0);
		queue_event(CMD_TICK, 16'h0000, 63'd60000099, 1'b0);
		queue_event(CMD_TICK, 16'hFFFF, 63'd60000100, 1'b0);
		queue_event(CMD_TICK, 16'h0000, TIME_MAX, 1'b0);
		// fill the table, overflow it, then expire nearly all at once
		for (int i = 1; i < DEPTH; i++)
			queue_event(CMD_HEARTBEAT, i[ID_W-1:0], 63'd1000, 1'b0);
		queue_event(CMD_HEARTBEAT, 16'd100, 63'd2000, 1'b0);
		queue_event(CMD_TICK, 16'd0, TIME_MAX, 1'b1);
		wait_drained();

		// zero timeout: anything not seen in the future expires
		write_timeout('0);
		queue_event(CMD_HEARTBEAT, 16'h1234, 63'd500, 1'b0);
		queue_event(CMD_HEARTBEAT, 16'hABCD, 63'd400, 1'b0);
		queue_event(CMD_TICK, 16'h0000, 63'd450, 1'b0);
		queue_event(CMD_TICK, 16'h0000, TIME_MAX, 1'b0);
		queue_event(CMD_TICK, 16'h0000, '0, 1'b0);
		wait_drained();

		// random phases over several timeouts
		phase_timeout[0] = 32'd1;
		phase_timeout[1] = 32'hFFFF_FFFF;
		phase_timeout[2] = $urandom_range(50, 2000);
		phase_timeout[3] = TIMEOUT_RESET;
		phase_timeout[4] = $urandom;
		for (int p = 0; p < 5; p++) begin
			write_timeout(phase_timeout[p]);
			quiet = (p == 2);
			queue_random_phase(46);
			wait_drained();
		end
		quiet = 1'b0;

		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_TIME);
		$display("%0t: timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/hbt_pkg.sv
design/hbt_cell.sv
design/heartbeat_timeout_table_top.sv
design/hbt_checker.sv
test/tb_heartbeat_timeout_table_top.sv
